/* rtl/ows_pkg.sv */
package ows_pkg;

    localparam int ROM_W    = 64;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 6;
    localparam int CRC_W    = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BIT     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BIT       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RESTARTED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd6;

    localparam logic [CRC_W-1:0] CRC_POLY       = 8'h8C;
    localparam logic [IDX_W-1:0] CRC_DATA_BITS  = 6'd56;
    localparam logic [POS_W:0]   POS_PAST_LAST  = 8'd65;
    localparam logic [POS_W-1:0] POS_FIRST      = 7'd1;
    localparam logic [POS_W-1:0] POS_NONE       = 7'd0;

    typedef struct packed {
        logic [ROM_W-1:0] rom;
        logic [POS_W-1:0] last_disc;
        logic             done;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] marker;
        logic [CRC_W-1:0] crc;
        logic             active;
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             bus_empty;
        logic             id_bit;
        logic             complement_bit;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                dir_bit;
        logic [ROM_W-1:0]    rom_code;
        logic                more_remaining;
    } t_res;

    function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc, input logic b);
        logic [CRC_W-1:0] sh;
        sh = crc >> 1;
        return (crc[0] ^ b) ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

/* rtl/ows_step.sv */
module ows_step (
    input  ows_pkg::t_state i_state,
    input  ows_pkg::t_item  i_item,
    output ows_pkg::t_state o_state,
    output ows_pkg::t_res   o_res
);

    ows_pkg::t_state             n_state;
    logic [ows_pkg::STATUS_W-1:0] status;
    logic                         wbit;
    logic                         more;
    logic                         g;
    logic [ows_pkg::POS_W-1:0]    m_minus_1;
    logic [ows_pkg::IDX_W-1:0]    idx;
    logic [ows_pkg::POS_W:0]      m_next;

    assign m_minus_1 = i_state.pos - ows_pkg::POS_FIRST;
    assign idx       = m_minus_1[ows_pkg::IDX_W-1:0];
    assign m_next    = {1'b0, i_state.pos} + {1'b0, ows_pkg::POS_FIRST};

    always_comb begin
        n_state = i_state;
        status  = ows_pkg::ST_IGNORED;
        wbit    = 1'b0;
        more    = 1'b0;
        g       = 1'b0;
        unique case (i_item.command)
            ows_pkg::CMD_RESTART: begin
                n_state.last_disc = ows_pkg::POS_NONE;
                n_state.done      = 1'b0;
                n_state.active    = 1'b0;
                status            = ows_pkg::ST_RESTARTED;
            end
            ows_pkg::CMD_BEGIN: begin
                if (i_item.bus_empty || i_state.done) begin
                    n_state.last_disc = ows_pkg::POS_NONE;
                    n_state.active    = 1'b0;
                    status            = ows_pkg::ST_OVER;
                end else begin
                    n_state.active = 1'b1;
                    n_state.pos    = ows_pkg::POS_FIRST;
                    n_state.marker = ows_pkg::POS_NONE;
                    n_state.crc    = '0;
                    status         = ows_pkg::ST_STARTED;
                end
            end
            ows_pkg::CMD_BIT: begin
                if (i_state.active) begin
                    if (i_item.id_bit && i_item.complement_bit) begin
                        n_state.last_disc = ows_pkg::POS_NONE;
                        n_state.active    = 1'b0;
                        status            = ows_pkg::ST_FAILED;
                    end else begin
                        if (i_item.id_bit || i_item.complement_bit) begin
                            g = i_item.id_bit;
                        end else begin
                            if (i_state.pos < i_state.last_disc) begin
                                g = i_state.rom[idx];
                            end else begin
                                g = (i_state.pos == i_state.last_disc);
                            end
                            if (!g) begin
                                n_state.marker = i_state.pos;
                            end
                        end
                        n_state.rom[idx] = g;
                        if (idx < ows_pkg::CRC_DATA_BITS) begin
                            n_state.crc = ows_pkg::crc_bit(i_state.crc, g);
                        end
                        wbit        = g;
                        n_state.pos = m_next[ows_pkg::POS_W-1:0];
                        if (m_next >= ows_pkg::POS_PAST_LAST) begin
                            n_state.active = 1'b0;
                            if (n_state.rom[ows_pkg::ROM_W-1 -: ows_pkg::CRC_W] == n_state.crc)
                            begin
                                n_state.last_disc = n_state.marker;
                                n_state.done      = (n_state.marker == ows_pkg::POS_NONE);
                                more              = (n_state.marker != ows_pkg::POS_NONE);
                                status            = ows_pkg::ST_FOUND;
                            end else begin
                                n_state.last_disc = ows_pkg::POS_NONE;
                                status            = ows_pkg::ST_FAILED;
                            end
                        end else begin
                            status = ows_pkg::ST_BIT;
                        end
                    end
                end
            end
            ows_pkg::CMD_UNUSED: begin
                status = ows_pkg::ST_IGNORED;
            end
        endcase
    end

    assign o_state              = n_state;
    assign o_res.status         = status;
    assign o_res.dir_bit        = wbit;
    assign o_res.rom_code       = n_state.rom;
    assign o_res.more_remaining = more;

endmodule

/* rtl/onewire_rom_search_top.sv */
// Channel  Dir  tdata (low bit up)                     tuser
// s_axis   in   bus_empty, id_bit, complement_bit      command
// m_axis   out  dir_bit, rom_code[63:0], more_rem.     status
//
// Each word passes the input and result registers; one word per cycle unless m_axis stalls.
// The search state updates in the same cycle the result register loads.
// Synchronous active-low reset clears the search state and both valid flags.
// A stalled m_axis holds the input register, then backs up into s_axis.
module onewire_rom_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // bus_empty, id_bit, complement_bit, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // dir_bit, rom_code[63:0], more_remaining, zero pad
    output logic [2:0]  o_m_axis_tuser    // status
);

    ows_pkg::t_state r_state;
    ows_pkg::t_state n_state;
    ows_pkg::t_item  r_in;
    ows_pkg::t_res   r_res;
    ows_pkg::t_res   n_res;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            out_free;
    logic            proc;
    logic            take;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    ows_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{rom: '0, last_disc: ows_pkg::POS_NONE, done: 1'b0,
                             pos: ows_pkg::POS_FIRST, marker: ows_pkg::POS_NONE,
                             crc: '0, active: 1'b0};
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.command        <= i_s_axis_tuser;
            r_in.bus_empty      <= i_s_axis_tdata[0];
            r_in.id_bit         <= i_s_axis_tdata[1];
            r_in.complement_bit <= i_s_axis_tdata[2];
        end
        if (proc) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_res.status;
    assign o_m_axis_tdata  = {6'd0, r_res.more_remaining, r_res.rom_code, r_res.dir_bit};

`ifndef ASSERT_OFF
    a_more_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.more_remaining |-> r_res.status == ows_pkg::ST_FOUND)
        else $error("more_remaining outside device found");

    a_found_more_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status == ows_pkg::ST_FOUND
        |-> r_res.more_remaining == !r_state.done)
        else $error("more_remaining disagrees with search done");

    a_closed_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.status == ows_pkg::ST_FOUND || r_res.status == ows_pkg::ST_FAILED
        || r_res.status == ows_pkg::ST_OVER || r_res.status == ows_pkg::ST_RESTARTED)
        |-> !r_state.active)
        else $error("pass still open after closing status");

    a_open_after_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.status == ows_pkg::ST_STARTED || r_res.status == ows_pkg::ST_BIT)
        |-> r_state.active)
        else $error("pass closed after started or bit status");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.active |-> (r_state.pos >= ows_pkg::POS_FIRST
        && {1'b0, r_state.pos} < ows_pkg::POS_PAST_LAST))
        else $error("bit position out of range in open pass");
`endif

endmodule

/* test/tb_onewire_rom_search_top.sv */
module tb_onewire_rom_search_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 470;
    localparam int MAX_DEVICES    = 4;
    localparam int N_DIRECTED     = 20;

    typedef struct packed {
        logic [ows_pkg::CMD_W-1:0]    cmd;
        logic                         empty;
        logic                         idb;
        logic                         cmpb;
        logic                         typed;
        logic [ows_pkg::STATUS_W-1:0] status;
        logic                         wbit;
        logic [ows_pkg::ROM_W-1:0]    rom;
        logic                         more;
    } t_row;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ows_pkg::CMD_BIT, 1'b0, 1'b1, 1'b0, 1'b1, ows_pkg::ST_IGNORED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, ows_pkg::ST_IGNORED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BEGIN, 1'b1, 1'b0, 1'b0, 1'b1, ows_pkg::ST_OVER, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_RESTART, 1'b0, 1'b0, 1'b0, 1'b1, ows_pkg::ST_RESTARTED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BEGIN, 1'b0, 1'b1, 1'b1, 1'b1, ows_pkg::ST_STARTED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b1, 1'b1, 1'b1, ows_pkg::ST_FAILED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b0, 1'b0, 1'b1, ows_pkg::ST_IGNORED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BEGIN, 1'b0, 1'b0, 1'b0, 1'b1, ows_pkg::ST_STARTED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b0, 1'b0, 1'b1, ows_pkg::ST_BIT, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b1, 1'b0, 1'b1, ows_pkg::ST_BIT, 1'b1, 64'h2, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b0, 1'b1, 1'b1, ows_pkg::ST_BIT, 1'b0, 64'h2, 1'b0},
        '{ows_pkg::CMD_UNUSED, 1'b0, 1'b0, 1'b0, 1'b1, ows_pkg::ST_IGNORED, 1'b0, 64'h2, 1'b0},
        '{ows_pkg::CMD_BEGIN, 1'b1, 1'b0, 1'b0, 1'b1, ows_pkg::ST_OVER, 1'b0, 64'h2, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b1, 1'b0, 1'b0, 1'b1, ows_pkg::ST_IGNORED, 1'b0, 64'h2, 1'b0},
        '{ows_pkg::CMD_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0, ows_pkg::ST_STARTED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b1, 1'b0, 1'b0, ows_pkg::ST_BIT, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BEGIN, 1'b0, 1'b1, 1'b1, 1'b0, ows_pkg::ST_STARTED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b1, 1'b0, 1'b0, 1'b0, ows_pkg::ST_BIT, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_RESTART, 1'b1, 1'b1, 1'b1, 1'b0, ows_pkg::ST_RESTARTED, 1'b0, 64'h0, 1'b0},
        '{ows_pkg::CMD_BIT, 1'b0, 1'b1, 1'b1, 1'b0, ows_pkg::ST_IGNORED, 1'b0, 64'h0, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // bus_empty, id_bit, complement_bit, zero pad
    logic [1:0]  i_s_axis_tuser = '0;   // command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;        // dir_bit, rom_code[63:0], more_remaining, zero pad
    logic [2:0]  o_m_axis_tuser;        // status

    // search state mirror
    logic [ows_pkg::ROM_W-1:0] rom_reg;
    logic [ows_pkg::POS_W-1:0] last_disc;
    logic                      done_flag;
    logic [ows_pkg::POS_W-1:0] bit_pos;
    logic [ows_pkg::POS_W-1:0] disc_mark;
    logic [ows_pkg::CRC_W-1:0] crc_acc;
    logic                      in_pass;

    ows_pkg::t_res pending_results[$];
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   tx_idle_pct = 26;
    int   rx_idle_pct = 74;
    bit   hold_request = 1'b0;
    int   quiet_cycles = 0;

    logic [ows_pkg::ROM_W-1:0] devices [MAX_DEVICES];
    int                        n_devices;

    onewire_rom_search_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [ows_pkg::CRC_W-1:0] crc8_shift(
        input logic [ows_pkg::CRC_W-1:0] c, input logic b);
        return {1'b0, c[ows_pkg::CRC_W-1:1]}
               ^ ({ows_pkg::CRC_W{c[0] ^ b}} & ows_pkg::CRC_POLY);
    endfunction

    function automatic logic [ows_pkg::ROM_W-1:0] rom_with_crc(input logic [55:0] body);
        logic [ows_pkg::CRC_W-1:0] c;
        c = '0;
        for (int i = 0; i < 56; i++) c = crc8_shift(c, body[i]);
        return {c, body};
    endfunction

    function automatic ows_pkg::t_res search_step(input ows_pkg::t_item it);
        ows_pkg::t_res             r;
        logic [ows_pkg::POS_W:0]   m;
        logic [ows_pkg::POS_W-1:0] pm1;
        logic [ows_pkg::IDX_W-1:0] idx;
        logic                      g;
        r = '0;
        r.status = ows_pkg::ST_IGNORED;
        case (it.command)
            ows_pkg::CMD_RESTART: begin
                last_disc = ows_pkg::POS_NONE;
                done_flag = 1'b0;
                in_pass   = 1'b0;
                r.status  = ows_pkg::ST_RESTARTED;
            end
            ows_pkg::CMD_BEGIN: begin
                if (it.bus_empty || done_flag) begin
                    last_disc = ows_pkg::POS_NONE;
                    in_pass   = 1'b0;
                    r.status  = ows_pkg::ST_OVER;
                end else begin
                    in_pass   = 1'b1;
                    bit_pos   = ows_pkg::POS_FIRST;
                    disc_mark = ows_pkg::POS_NONE;
                    crc_acc   = '0;
                    r.status  = ows_pkg::ST_STARTED;
                end
            end
            ows_pkg::CMD_BIT: begin
                if (in_pass) begin
                    if (it.id_bit && it.complement_bit) begin
                        last_disc = ows_pkg::POS_NONE;
                        in_pass   = 1'b0;
                        r.status  = ows_pkg::ST_FAILED;
                    end else begin
                        pm1 = bit_pos - ows_pkg::POS_FIRST;
                        idx = pm1[ows_pkg::IDX_W-1:0];
                        if (it.id_bit || it.complement_bit) begin
                            g = it.id_bit;
                        end else begin
                            if (bit_pos < last_disc) g = rom_reg[idx];
                            else g = (bit_pos == last_disc);
                            if (!g) disc_mark = bit_pos;
                        end
                        rom_reg[idx] = g;
                        if (idx < ows_pkg::CRC_DATA_BITS) crc_acc = crc8_shift(crc_acc, g);
                        r.dir_bit = g;
                        m = {1'b0, bit_pos} + 1'b1;
                        bit_pos = m[ows_pkg::POS_W-1:0];
                        if (m >= ows_pkg::POS_PAST_LAST) begin
                            in_pass = 1'b0;
                            if (rom_reg[63:56] == crc_acc) begin
                                last_disc        = disc_mark;
                                done_flag        = (disc_mark == ows_pkg::POS_NONE);
                                r.more_remaining = !done_flag;
                                r.status         = ows_pkg::ST_FOUND;
                            end else begin
                                last_disc = ows_pkg::POS_NONE;
                                r.status  = ows_pkg::ST_FAILED;
                            end
                        end else begin
                            r.status = ows_pkg::ST_BIT;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.rom_code = rom_reg;
        return r;
    endfunction

    task automatic send_word(input ows_pkg::t_item it, input bit typed,
                             input ows_pkg::t_res typed_res, output ows_pkg::t_res got);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, it.complement_bit, it.id_bit, it.bus_empty};
        i_s_axis_tuser  <= it.command;
        do @(posedge i_clk); while (!o_s_axis_tready);
        got = search_step(it);
        pending_results.push_back(typed ? typed_res : got);
        items_sent++;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one search over a freshly populated bus, with occasional faults and noise
    task automatic run_search();
        ows_pkg::t_item it;
        ows_pkg::t_res  got;
        logic [55:0] base;
        logic [55:0] body;
        logic [MAX_DEVICES-1:0] live;
        logic        idb;
        logic        cmpb;
        bit          aborted;
        n_devices = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, MAX_DEVICES);
        base = 56'({$urandom, $urandom});
        for (int k = 0; k < MAX_DEVICES; k++) begin
            case ($urandom_range(15))
                0:       body = '0;
                1:       body = '1;
                2, 3, 4: body = 56'({$urandom, $urandom});
                default: body = base ^ (56'h1 << $urandom_range(55))
                                     ^ (56'h1 << $urandom_range(55));
            endcase
            devices[k] = rom_with_crc(body);
            if ($urandom_range(9) == 0) devices[k][63:56] ^= 8'h1 << $urandom_range(7);
        end
        if ($urandom_range(4) != 0) begin
            it = '0;
            it.command = ows_pkg::CMD_RESTART;
            send_word(it, 1'b0, '0, got);
        end
        for (int p = 0; p < n_devices + 2; p++) begin
            it = '0;
            it.command = ows_pkg::CMD_BEGIN;
            it.bus_empty = (n_devices == 0) ? ($urandom_range(3) != 0)
                                            : ($urandom_range(19) == 0);
            send_word(it, 1'b0, '0, got);
            if (got.status != ows_pkg::ST_STARTED) continue;
            for (int k = 0; k < MAX_DEVICES; k++) live[k] = (k < n_devices);
            aborted = 1'b0;
            for (int b = 0; b < ows_pkg::ROM_W && !aborted; b++) begin
                if ($urandom_range(149) == 0) begin
                    it = 5'($urandom_range(0, 31));
                    send_word(it, 1'b0, '0, got);
                    aborted = 1'b1;
                end else begin
                    idb  = 1'b1;
                    cmpb = 1'b1;
                    for (int k = 0; k < MAX_DEVICES; k++) begin
                        if (live[k]) begin
                            idb  &= devices[k][b];
                            cmpb &= !devices[k][b];
                        end
                    end
                    if ($urandom_range(299) == 0) begin
                        idb  = 1'b1;
                        cmpb = 1'b1;
                    end
                    it = '0;
                    it.command = ows_pkg::CMD_BIT;
                    it.bus_empty = 1'($urandom_range(1));
                    it.id_bit = idb;
                    it.complement_bit = cmpb;
                    send_word(it, 1'b0, '0, got);
                    for (int k = 0; k < MAX_DEVICES; k++)
                        if (devices[k][b] != got.dir_bit) live[k] = 1'b0;
                    if (got.status != ows_pkg::ST_BIT) aborted = 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : rx_drive
        int hold_left;
        bit hold_taken;
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        ows_pkg::t_res want;
        ows_pkg::t_res got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status         = o_m_axis_tuser;
            got.dir_bit        = o_m_axis_tdata[0];
            got.rom_code       = o_m_axis_tdata[64:1];
            got.more_remaining = o_m_axis_tdata[65];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: status %0d rom %h", got.status, got.rom_code);
            end else begin
                want = pending_results.pop_front();
                if (want.status != got.status || want.dir_bit != got.dir_bit ||
                    want.rom_code != got.rom_code ||
                    want.more_remaining != got.more_remaining) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display(
                            "exp st %0d db %0d rom %h mr %0d / got st %0d db %0d rom %h mr %0d",
                            want.status, want.dir_bit, want.rom_code,
                            want.more_remaining, got.status, got.dir_bit,
                            got.rom_code, got.more_remaining);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL onewire_rom_search_top");
            $finish;
        end
    end

    initial begin : main_seq
        ows_pkg::t_item it;
        ows_pkg::t_res  want;
        ows_pkg::t_res  got;
        rom_reg   = '0;
        last_disc = ows_pkg::POS_NONE;
        done_flag = 1'b0;
        bit_pos   = ows_pkg::POS_FIRST;
        disc_mark = ows_pkg::POS_NONE;
        crc_acc   = '0;
        in_pass   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            it.command        = DIRECTED[i].cmd;
            it.bus_empty      = DIRECTED[i].empty;
            it.id_bit         = DIRECTED[i].idb;
            it.complement_bit = DIRECTED[i].cmpb;
            want.status         = DIRECTED[i].status;
            want.dir_bit        = DIRECTED[i].wbit;
            want.rom_code       = DIRECTED[i].rom;
            want.more_remaining = DIRECTED[i].more;
            send_word(it, DIRECTED[i].typed, want, got);
        end

        while (items_sent < PHASE_ITEMS) run_search();
        tx_idle_pct = 74;
        rx_idle_pct = 26;
        while (items_sent < 2 * PHASE_ITEMS) run_search();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b1;
        while (items_sent < 3 * PHASE_ITEMS) run_search();

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS onewire_rom_search_top");
        end else begin
            $display("FAIL onewire_rom_search_top");
        end
        $finish;
    end

endmodule

/* onewire_rom_search_top.f */
rtl/ows_pkg.sv
rtl/ows_step.sv
rtl/onewire_rom_search_top.sv
test/tb_onewire_rom_search_top.sv
